>>> hw/rtl/utu_pkg.sv
// Shared types and constants for the UTF-8 to USB string unit decoder.
package utu_pkg;

    // Largest number of string units in one string.
    localparam logic [6:0] MAX_UNITS = 7'd127;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_TOO_MANY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [6:0]  unit_index;
        status_t     status;
        logic        last;
    } result_t;

    // Decoder to result register: one result or none per stepped byte.
    typedef struct packed {
        logic    valid;
        result_t res;
    } dec_out_t;

endpackage

>>> hw/rtl/utu_decode.sv
// Byte decoder: continuation count, code point accumulator and unit counter.
module utu_decode
    import utu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic       end_of_string,
    output dec_out_t   dec_out
);

    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    // Only the low 16 bits of a code point are ever shown, so keep just those.
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [6:0]  count_reg;
    logic [6:0]  count_next;
    logic        complete;
    logic        bad_lead;

    always_comb
    begin
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        complete   = 1'b0;
        bad_lead   = 1'b0;
        dec_out    = '0;
        dec_out.res.unit_index = count_reg;
        dec_out.res.status     = ST_OK;

        if (pend_reg == 2'd0)
        begin
            priority if (!byte_in[7])
            begin
                acc_next = {8'd0, byte_in};
                complete = 1'b1;
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                acc_next  = {11'd0, byte_in[4:0]};
                pend_next = 2'd1;
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                acc_next  = {12'd0, byte_in[3:0]};
                pend_next = 2'd2;
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                acc_next  = {13'd0, byte_in[2:0]};
                pend_next = 2'd3;
            end
            else
            begin
                bad_lead = 1'b1;
            end
        end
        else
        begin
            acc_next  = {acc_reg[9:0], byte_in[5:0]};
            pend_next = pend_reg - 2'd1;
            complete  = (pend_reg == 2'd1);
        end

        priority if (bad_lead)
        begin
            dec_out.valid      = 1'b1;
            dec_out.res.status = ST_BAD_LEAD;
            dec_out.res.last   = 1'b1;
        end
        else if (!complete)
        begin
            if (end_of_string)
            begin
                dec_out.valid      = 1'b1;
                dec_out.res.status = ST_TRUNCATED;
                dec_out.res.last   = 1'b1;
            end
        end
        else if (count_reg >= MAX_UNITS)
        begin
            dec_out.valid      = 1'b1;
            dec_out.res.status = ST_TOO_MANY;
            dec_out.res.last   = 1'b1;
        end
        else
        begin
            dec_out.valid         = 1'b1;
            dec_out.res.code_unit = acc_next;
            dec_out.res.last      = end_of_string;
            count_next            = count_reg + 7'd1;
            acc_next              = '0;
        end

        // Any result with last set starts a fresh string.
        if (dec_out.valid && dec_out.res.last)
        begin
            pend_next  = '0;
            acc_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/utu_out_reg.sv
// Result register between the decoder and the output stream.
module utu_out_reg
    import utu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  dec_out_t dec_out,
    output logic     load_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && dec_out.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && dec_out.valid)
        begin
            res_reg <= dec_out.res;
        end
    end

endmodule

>>> hw/rtl/utf8_to_utf16_units.sv
// Top level of the UTF-8 to USB string unit decoder.
//
// Feed the UTF-8 bytes of a string one per beat on s_axis, with tlast on the
// final byte. For each completed 1 to 4 byte character the block returns one
// beat on m_axis. The beat carries the low 16 bits of the code point (4-byte
// characters are truncated) and the unit's index within the string. The
// descriptor byte offset is twice the index. Continuation bytes are not
// checked, only their low six bits are used. m_axis_tuser carries the status.
// Errors come back as a single beat with tlast set and a zero code unit:
// status 1 for a bad lead byte, 2 for a string that ends inside a character,
// 3 for more than 127 units. After any beat with tlast the next byte starts a
// new string. Throughput is one byte per clock while results are taken. An
// accepted byte sits in the input register until the decoder steps. The
// decoder then writes its result into the result register, which drives
// m_axis. While a result waits to be taken the decoder holds. The input
// register takes one more byte, then s_axis_tready drops until the result
// beat goes out. s_axis_tready follows m_axis_tready combinationally.
module utf8_to_utf16_units
    import utu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] code_unit, [22:16] unit_index,
                                        // [23] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       advance;
    logic       load_ready;
    dec_out_t   dec_out;
    result_t    out_res;

    // Step the decoder whenever a byte is held and the result register can
    // take whatever it produces.
    assign advance       = in_valid_reg && load_ready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Hold the byte until the decoder steps.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    utu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .byte_in       (in_byte_reg),
        .end_of_string (in_eos_reg),
        .dec_out       (dec_out)
    );

    utu_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .dec_out    (dec_out),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.unit_index, out_res.code_unit};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

endmodule

>>> hw/rtl/utu_checker.sv
// Port-level checks for the decoder top level, bound to it.
module utu_checker
    import utu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

    // Error beats always end the string and carry no code unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |->
            m_axis_tlast && (m_axis_tdata[15:0] == 16'd0))
    else $error("error beat without tlast or with nonzero code unit");

    // Padding bit stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23] == 1'b0))
    else $error("pad bit set in result beat");

    // Unit index never reaches the unit limit on an ok beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) |->
            (m_axis_tdata[22:16] < MAX_UNITS))
    else $error("ok beat with index at or past the unit limit");

    // Every byte with tlast yields a result beat, checked for the case where the
    // receiver is ready while the decoder steps that byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast ##1 m_axis_tready
            |=> m_axis_tvalid)
    else $error("result beat missing");

endmodule

bind utf8_to_utf16_units utu_checker u_utu_checker (.*);

>>> test/tb_utf8_to_utf16_units.sv
// Self-checking testbench for the UTF-8 to USB string unit decoder.
module tb_utf8_to_utf16_units;
    import utu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any beat on either side before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int SHOWN_ERRORS = 10;

    // How a generated string is damaged, if at all.
    typedef enum int {
        FLAW_NONE,
        FLAW_TRUNCATED,
        FLAW_BAD_LEAD
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] byte_in
    logic        s_axis_tlast;     // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [15:0] code_unit, [22:16] unit_index,
                                   // [23] zero
    logic [1:0]  m_axis_tuser;     // [1:0] status
    logic        m_axis_tlast;     // last

    // Decoder shadow state, advanced on every accepted input beat.
    logic [1:0]  dec_pending = '0;
    logic [20:0] dec_acc     = '0;
    logic [6:0]  dec_count   = '0;

    // Units the block still owes us, oldest first.
    result_t     expected_units[$];

    int          err_count        = 0;
    int          bytes_sent       = 0;
    int          stall_cycles     = 0;
    int          sink_hold_cycles = 0;
    logic        src_idle_on      = 1'b1;
    logic        sink_idle_on     = 1'b1;

    utf8_to_utf16_units uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue the single beat that ends a string on an error, then drop all state.
    task automatic close_string(input status_t st);
        result_t r;
        r.code_unit  = '0;
        r.unit_index = dec_count;
        r.status     = st;
        r.last       = 1'b1;
        expected_units.push_back(r);
        dec_pending = '0;
        dec_acc     = '0;
        dec_count   = '0;
    endtask

    // Advance the shadow decoder by one byte and queue the unit it yields.
    task automatic predict_unit(input logic [7:0] b, input logic eos);
        logic    done;
        logic    bad;
        result_t r;
        done = 1'b0;
        bad  = 1'b0;
        if (dec_pending == 2'd0)
        begin
            // Lead byte: its prefix tells how many continuation bytes follow.
            if (!b[7])
            begin
                dec_acc = {13'd0, b};
                done    = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                dec_acc     = {16'd0, b[4:0]};
                dec_pending = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                dec_acc     = {17'd0, b[3:0]};
                dec_pending = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                dec_acc     = {18'd0, b[2:0]};
                dec_pending = 2'd3;
            end
            else
                bad = 1'b1;
        end
        else
        begin
            // Continuation: the top two bits are not looked at.
            dec_acc     = {dec_acc[14:0], b[5:0]};
            dec_pending = dec_pending - 2'd1;
            done        = (dec_pending == 2'd0);
        end

        if (bad)
            close_string(ST_BAD_LEAD);
        else if (!done)
        begin
            if (eos)
                close_string(ST_TRUNCATED);
        end
        else if (dec_count >= MAX_UNITS)
            close_string(ST_TOO_MANY);
        else
        begin
            // Four-byte characters lose everything above bit 15 here.
            r.code_unit  = dec_acc[15:0];
            r.unit_index = dec_count;
            r.status     = ST_OK;
            r.last       = eos;
            expected_units.push_back(r);
            dec_acc = '0;
            if (eos)
            begin
                dec_pending = '0;
                dec_count   = '0;
            end
            else
                dec_count = dec_count + 7'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte beat, maybe after an idle burst, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_unit(b, eos);
        bytes_sent++;
    endtask

    // Send the first keep bytes of a random len-byte character. Continuation
    // bytes sometimes carry a wrong prefix, which the block must ignore.
    task automatic send_char(input int len, input int keep, input logic eos);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case (len)
            1:       b[7]   = 1'b0;
            2:       b[7:5] = 3'b110;
            3:       b[7:4] = 4'b1110;
            default: b[7:3] = 5'b11110;
        endcase
        send_byte(b, eos && keep == 1);
        for (int i = 1; i < keep; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) != 0)
                b[7:6] = 2'b10;
            send_byte(b, eos && i == keep - 1);
        end
    endtask

    // Send a string of random characters, optionally broken.
    task automatic send_string(input int n_chars, input flaw_t flaw);
        int         len;
        int         bad_at;
        logic [7:0] b;
        bad_at = (flaw == FLAW_BAD_LEAD) ? $urandom_range(0, n_chars - 1) : -1;
        for (int k = 0; k < n_chars; k++)
        begin
            if (k == bad_at)
            begin
                // Stray continuation byte or an over-long 11111xxx prefix.
                b = 8'($urandom_range(0, 255));
                if (b[6])
                    b[7:3] = 5'b11111;
                else
                    b[7:6] = 2'b10;
                send_byte(b, $urandom_range(0, 3) == 0);
            end
            len = $urandom_range(1, 4);
            if (k == n_chars - 1 && flaw == FLAW_TRUNCATED)
            begin
                len = $urandom_range(2, 4);
                send_char(len, $urandom_range(1, len - 1), 1'b1);
            end
            else
                send_char(len, len, k == n_chars - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver readiness: a requested long hold-off, random idle bursts,
    // or always ready once idling is turned off.
    initial
    begin : sink_ready
        int gap;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold_cycles = 0;
                m_axis_tready = 1'b1;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 9);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            err_count++;
            if (err_count <= SHOWN_ERRORS)
                $display("mismatch in %s at %0t: expected %0h, got %0h",
                         name, $time, want, got);
        end
    endtask

    // Compare every result beat against the oldest predicted unit.
    always @(posedge clk)
    begin : check_units
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_units.size() == 0)
            begin
                err_count++;
                if (err_count <= SHOWN_ERRORS)
                    $display("unexpected beat at %0t: tdata %0h tuser %0h tlast %0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = expected_units.pop_front();
                compare_field("code_unit", 32'(want.code_unit),
                              32'(m_axis_tdata[15:0]));
                compare_field("unit_index", 32'(want.unit_index),
                              32'(m_axis_tdata[22:16]));
                compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                compare_field("tlast", 32'(want.last), 32'(m_axis_tlast));
                compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[23]));
            end
        end
    end

    // Hang detector: any accepted beat on either side resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the one-byte range inside a two-unit string.
    task automatic test_single_bytes;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Smallest and largest payloads of each multi-byte form; the 4-byte ones
    // come out truncated to 16 bits. One 3-byte character carries
    // continuation bytes with wrong prefixes.
    task automatic test_multi_byte;
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // Bad lead bytes at the start of a string and after one good unit;
    // end_of_string on a bad lead changes nothing.
    task automatic test_bad_lead;
        send_byte(8'h80, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Strings that end right after a lead byte and one byte short of a
    // 4-byte character.
    task automatic test_truncated;
        send_byte(8'hC2, 1'b1);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // A string of exactly the maximum length passes; one unit more fails
    // with the index at the limit, and the next byte starts a fresh string.
    task automatic test_too_many;
        send_string(MAX_UNITS, FLAW_NONE);
        for (int k = 0; k < MAX_UNITS; k++)
            send_char(1, 1, 1'b0);
        send_char(2, 2, 1'b0);
        send_char(1, 1, 1'b1);
    endtask

    // Stall the receiver long enough for the block to fill and push back.
    task automatic test_backpressure;
        sink_hold_cycles = HOLD_CYCLES;
        send_string(40, FLAW_NONE);
    endtask

    // Mostly well-formed strings, some broken, some raw noise. The final
    // stretch runs with both sides always ready.
    task automatic test_random_strings;
        int goal;
        int pick;
        int n;
        goal = bytes_sent + 520;
        while (bytes_sent < goal)
        begin
            if (goal - bytes_sent < 200)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 130)
                                             : $urandom_range(1, 12);
            if (pick < 70)
                send_string(n, FLAW_NONE);
            else if (pick < 80)
                send_string(n, FLAW_TRUNCATED);
            else if (pick < 90)
                send_string(n, FLAW_BAD_LEAD);
            else
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_bytes;
        test_multi_byte;
        test_bad_lead;
        test_truncated;
        test_too_many;
        test_backpressure;
        test_random_strings;

        // Drop valid, drain what is owed, then watch a while for extra beats.
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
